// File: hw/rtl/workgroup_wave_placement_assert.svh
// assertion macros shared by the workgroup wave placement rtl
`ifndef WORKGROUP_WAVE_PLACEMENT_ASSERT_SVH
`define WORKGROUP_WAVE_PLACEMENT_ASSERT_SVH
`ifndef ASSERT_OFF
`define WWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define WWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define WWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/wwp_pkg.sv
// shared types and constants for the workgroup wave placement block
`timescale 1ns / 1ps

package wwp_pkg;

    // parameter defaults
    localparam int LANES_PER_WAVE_DEF = 64;
    localparam int MAX_THREADS_DEF    = 1024;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_Z   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_THREADS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UNITS_CL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_UNITS    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ENGINES  = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_GRID = 2'd1;
    localparam logic [1:0] ST_NO_UNITS = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // shared divider width
    localparam int DIV_W = 32;

    // wave index width, bounds the waves per workgroup
    localparam int WAVE_IDX_W = 4;

    typedef struct packed {
        logic [15:0] grid_x;
        logic [15:0] grid_y;
        logic [15:0] grid_z;
        logic [10:0] threads;
        logic [7:0]  units_cl;
        logic [11:0] units;
        logic [7:0]  engines;
        logic        err_grid;
        logic        err_units;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

// File: hw/rtl/wwp_cfg_regs.sv
// configuration registers and setup checks for the workgroup wave placement block
`timescale 1ns / 1ps

module wwp_cfg_regs
    import wwp_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    localparam logic [12:0] MAX_THR = 13'(MAX_THREADS);

    logic [15:0] r_grid_x;
    logic [15:0] r_grid_y;
    logic [15:0] r_grid_z;
    logic [10:0] r_threads;
    logic [7:0]  r_units_cl;
    logic [11:0] r_units;
    logic [7:0]  r_engines;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_x   <= 16'd1;
            r_grid_y   <= 16'd1;
            r_grid_z   <= 16'd1;
            r_threads  <= 11'd64;
            r_units_cl <= 8'd1;
            r_units    <= 12'd1;
            r_engines  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GRID_X:   r_grid_x   <= i_cfg_wdata;
                REG_GRID_Y:   r_grid_y   <= i_cfg_wdata;
                REG_GRID_Z:   r_grid_z   <= i_cfg_wdata;
                REG_THREADS:  r_threads  <= i_cfg_wdata[10:0];
                REG_UNITS_CL: r_units_cl <= i_cfg_wdata[7:0];
                REG_UNITS:    r_units    <= i_cfg_wdata[11:0];
                REG_ENGINES:  r_engines  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // setup checks
    always_comb begin
        o_cfg.grid_x    = r_grid_x;
        o_cfg.grid_y    = r_grid_y;
        o_cfg.grid_z    = r_grid_z;
        o_cfg.threads   = r_threads;
        o_cfg.units_cl  = r_units_cl;
        o_cfg.units     = r_units;
        o_cfg.engines   = r_engines;
        o_cfg.err_grid  = (r_grid_x == 16'd0) || (r_grid_y == 16'd0) ||
                          (r_grid_z == 16'd0) || (r_threads == 11'd0) ||
                          ({2'b00, r_threads} > MAX_THR);
        o_cfg.err_units = (r_units_cl == 8'd0) || (r_units == 12'd0) ||
                          (r_engines == 8'd0);
    end

endmodule

// File: hw/rtl/wwp_divider.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wwp_divider
    import wwp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W:0]   partial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] n_rem;
    logic             q_bit;

    // one shift and trial subtract
    always_comb begin
        partial = {r_rem, r_quo[DIV_W-1]};
        diff    = partial - {1'b0, r_div};
        q_bit   = (partial >= {1'b0, r_div});
        n_rem   = q_bit ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// File: hw/rtl/workgroup_wave_placement.sv
// Workgroup wave placement: top level with the placement sequencer and wave output.
//
// A request is taken at a clock edge with start high and busy low; i_group_id
// is sampled then. busy stays high while the request is worked on.
// Configuration registers are written through i_cfg_we / i_cfg_addr /
// i_cfg_wdata, which the user must do only while the block is idle; the block
// itself does not enforce this. Index 7 is ignored.
// Each result appears for one cycle with o_valid high; the receiver cannot
// hold results off, so results leave at one per cycle.
// A grid, group size or unit count error gives a single result in the cycle
// after the request, with busy staying low.
// Otherwise the request runs five divisions in turn on one shared 32-step divider
// (id / grid_x, quotient / grid_y, id / plane, id / total_units, then
// unit / units_per_cluster) before the waves. An id beyond the grid ends
// after the third division with one error result.
// The waves follow back to back, one per cycle, up to sixteen, the final one
// with o_last; busy drops with it.
// Reset is synchronous and active low; configuration and control registers
// return to their reset values and any request in flight is dropped.
`timescale 1ns / 1ps
`include "workgroup_wave_placement_assert.svh"

module workgroup_wave_placement
    import wwp_pkg::*;
#(
    parameter int LANES_PER_WAVE = LANES_PER_WAVE_DEF,
    parameter int MAX_THREADS    = MAX_THREADS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           i_group_id,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [15:0]           o_coord_x,
    output logic [15:0]           o_coord_y,
    output logic [15:0]           o_coord_z,
    output logic [11:0]           o_cluster_id,
    output logic [7:0]            o_unit_in_cluster,
    output logic [11:0]           o_global_unit,
    output logic [3:0]            o_wave_index,
    output logic [7:0]            o_engine_id,
    output logic [6:0]            o_active_lanes,
    output logic                  o_last
);

    localparam logic [11:0]           WS        = 12'(LANES_PER_WAVE);
    localparam logic [WAVE_IDX_W-1:0] WAVE_LAST = {WAVE_IDX_W{1'b1}};

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_X = 3'd1;
    localparam logic [2:0] S_DIV_Y = 3'd2;
    localparam logic [2:0] S_DIV_P = 3'd3;
    localparam logic [2:0] S_DIV_U = 3'd4;
    localparam logic [2:0] S_DIV_C = 3'd5;
    localparam logic [2:0] S_WAVE  = 3'd6;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [31:0] r_id;
    logic [31:0] r_plane;
    logic [15:0] r_cx;
    logic [15:0] r_cy;
    logic [15:0] r_cz;
    logic [11:0] r_gu;
    logic [11:0] r_cl;
    logic [7:0]  r_uic;
    logic [10:0] r_thr_left;
    logic [WAVE_IDX_W-1:0] r_wave;
    logic [7:0]  r_eng;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [15:0] r_out_cx;
    logic [15:0] r_out_cy;
    logic [15:0] r_out_cz;
    logic [11:0] r_out_cl;
    logic [7:0]  r_out_uic;
    logic [11:0] r_out_gu;
    logic [3:0]  r_out_wave;
    logic [7:0]  r_out_eng;
    logic [6:0]  r_out_lanes;
    logic        r_out_last;

    logic        accept;
    logic        out_of_range;
    logic [11:0] thr_left_ext;
    logic [11:0] lanes;
    logic        wave_last;
    logic [7:0]  eng_inc;
    logic        div_wait;

    wwp_cfg_regs #(
        .MAX_THREADS (MAX_THREADS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    wwp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign accept       = start && (r_state == S_IDLE);
    assign out_of_range = (div_rsp.quotient >= {16'd0, cfg.grid_z});

    // sequencer waits on the divider
    assign div_wait = (r_state == S_DIV_X) || (r_state == S_DIV_Y) ||
                      (r_state == S_DIV_P) || (r_state == S_DIV_U) ||
                      (r_state == S_DIV_C);

    // wave lane count and last flag
    assign thr_left_ext = {1'b0, r_thr_left};
    assign lanes        = (thr_left_ext < WS) ? thr_left_ext : WS;
    assign wave_last    = (thr_left_ext <= WS) || (r_wave == WAVE_LAST);
    assign eng_inc      = r_eng + 8'd1;

    // next state and divider launches
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start && !cfg.err_grid && !cfg.err_units) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = i_group_id;
                    div_req.divisor  = {16'd0, cfg.grid_x};
                    n_state          = S_DIV_X;
                end
            end
            S_DIV_X: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = {16'd0, cfg.grid_y};
                    n_state          = S_DIV_Y;
                end
            end
            S_DIV_Y: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_id;
                    div_req.divisor  = r_plane;
                    n_state          = S_DIV_P;
                end
            end
            S_DIV_P: begin
                if (div_rsp.done) begin
                    if (out_of_range) begin
                        n_state = S_IDLE;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = r_id;
                        div_req.divisor  = {20'd0, cfg.units};
                        n_state          = S_DIV_U;
                    end
                end
            end
            S_DIV_U: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {20'd0, div_rsp.remainder[11:0]};
                    div_req.divisor  = {24'd0, cfg.units_cl};
                    n_state          = S_DIV_C;
                end
            end
            S_DIV_C: begin
                if (div_rsp.done) begin
                    n_state = S_WAVE;
                end
            end
            S_WAVE: begin
                if (wave_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // placement results collected from the divider
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id    <= i_group_id;
            r_plane <= {16'd0, cfg.grid_x} * {16'd0, cfg.grid_y};
        end
        if (div_rsp.done) begin
            case (r_state)
                S_DIV_X: r_cx <= div_rsp.remainder[15:0];
                S_DIV_Y: r_cy <= div_rsp.remainder[15:0];
                S_DIV_P: r_cz <= div_rsp.quotient[15:0];
                S_DIV_U: r_gu <= div_rsp.remainder[11:0];
                S_DIV_C: begin
                    r_cl  <= div_rsp.quotient[11:0];
                    r_uic <= div_rsp.remainder[7:0];
                end
                default: ;
            endcase
        end
        // wave counters
        if (r_state == S_DIV_C && div_rsp.done) begin
            r_thr_left <= cfg.threads;
            r_wave     <= '0;
            r_eng      <= 8'd0;
        end else if (r_state == S_WAVE) begin
            r_thr_left <= 11'(thr_left_ext - WS);
            r_wave     <= r_wave + 1'b1;
            r_eng      <= (eng_inc == cfg.engines) ? 8'd0 : eng_inc;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (accept && (cfg.err_grid || cfg.err_units)) ||
                           (r_state == S_DIV_P && div_rsp.done && out_of_range) ||
                           (r_state == S_WAVE);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_WAVE) begin
            r_out_status <= ST_OK;
            r_out_cx     <= r_cx;
            r_out_cy     <= r_cy;
            r_out_cz     <= r_cz;
            r_out_cl     <= r_cl;
            r_out_uic    <= r_uic;
            r_out_gu     <= r_gu;
            r_out_wave   <= r_wave;
            r_out_eng    <= r_eng;
            r_out_lanes  <= lanes[6:0];
            r_out_last   <= wave_last;
        end else begin
            if (r_state == S_IDLE) begin
                r_out_status <= cfg.err_grid ? ST_BAD_GRID : ST_NO_UNITS;
            end else begin
                r_out_status <= ST_RANGE;
            end
            r_out_cx    <= '0;
            r_out_cy    <= '0;
            r_out_cz    <= '0;
            r_out_cl    <= '0;
            r_out_uic   <= '0;
            r_out_gu    <= '0;
            r_out_wave  <= '0;
            r_out_eng   <= '0;
            r_out_lanes <= '0;
            r_out_last  <= 1'b1;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_coord_x         = r_out_cx;
    assign o_coord_y         = r_out_cy;
    assign o_coord_z         = r_out_cz;
    assign o_cluster_id      = r_out_cl;
    assign o_unit_in_cluster = r_out_uic;
    assign o_global_unit     = r_out_gu;
    assign o_wave_index      = r_out_wave;
    assign o_engine_id       = r_out_eng;
    assign o_active_lanes    = r_out_lanes;
    assign o_last            = r_out_last;

    // an error result is always the last result of its request
    `WWP_ASSERT_IMP(a_err_single, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_last)
    // waves leave back to back until the last one
    `WWP_ASSERT_NXT(a_wave_run, i_clk, i_rst_n, o_valid && (o_status == ST_OK) && !o_last, o_valid)
    // the final result of a request finds the sequencer idle
    `WWP_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !busy)
    // divider answers only while the sequencer waits for it
    `WWP_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, div_rsp.done, div_wait)

endmodule

// File: tb/workgroup_wave_placement_tb.sv
// self-checking testbench for the workgroup wave placement block
`timescale 1ns / 1ps

module workgroup_wave_placement_tb;
    import wwp_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int TAIL_CYCLES      = 60;
    localparam int MAX_REPORTS      = 10;
    localparam int MAX_WAVES        = 1 << WAVE_IDX_W;
    localparam int RANDOM_PHASES    = 20;
    localparam int GROUPS_PER_PHASE = 18;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    // one wave result, fields in port order
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [15:0] coord_z;
        logic [11:0] cluster_id;
        logic [7:0]  unit_in_cluster;
        logic [11:0] global_unit;
        logic [3:0]  wave_index;
        logic [7:0]  engine_id;
        logic [6:0]  active_lanes;
        logic        last;
    } t_wave_rec;

    // placement predictor and queue of waves still to come
    class wave_placement_board;
        logic [15:0] grid_x;
        logic [15:0] grid_y;
        logic [15:0] grid_z;
        logic [10:0] threads;
        logic [7:0]  units_cl;
        logic [11:0] units;
        logic [7:0]  engines;
        t_wave_rec   pending_waves[$];
        int          mismatches;

        function new();
            grid_x     = 16'd1;
            grid_y     = 16'd1;
            grid_z     = 16'd1;
            threads    = 11'd64;
            units_cl   = 8'd1;
            units      = 12'd1;
            engines    = 8'd1;
            mismatches = 0;
        endfunction

        // register write, masked to each register width
        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRID_X:   grid_x   = data;
                REG_GRID_Y:   grid_y   = data;
                REG_GRID_Z:   grid_z   = data;
                REG_THREADS:  threads  = data[10:0];
                REG_UNITS_CL: units_cl = data[7:0];
                REG_UNITS:    units    = data[11:0];
                REG_ENGINES:  engines  = data[7:0];
                default: ;
            endcase
        endfunction

        // append one expected result
        function void add_wave(t_wave_rec r);
            pending_waves.insert(pending_waves.size(), r);
        endfunction

        // expected waves for one accepted request
        function void note_group(logic [31:0] id);
            longint unsigned gid, plane, total, gu, waves, w, base, rest;
            t_wave_rec r;
            r = '0;
            r.last = 1'b1;
            gid = id;
            // grid or group size error wins over everything
            if (grid_x == 0 || grid_y == 0 || grid_z == 0 || threads == 0 ||
                    threads > MAX_THREADS_DEF) begin
                r.status = ST_BAD_GRID;
                add_wave(r);
                return;
            end
            if (units_cl == 0 || units == 0 || engines == 0) begin
                r.status = ST_NO_UNITS;
                add_wave(r);
                return;
            end
            // exact grid product, no wrap
            plane = grid_x;
            plane = plane * grid_y;
            total = plane * grid_z;
            if (gid >= total) begin
                r.status = ST_RANGE;
                add_wave(r);
                return;
            end
            r.status          = ST_OK;
            r.coord_x         = 16'(gid % grid_x);
            r.coord_y         = 16'((gid / grid_x) % grid_y);
            r.coord_z         = 16'(gid / plane);
            gu                = gid % units;
            r.global_unit     = 12'(gu);
            r.cluster_id      = 12'(gu / units_cl);
            r.unit_in_cluster = 8'(gu % units_cl);
            waves = (threads + LANES_PER_WAVE_DEF - 1) / LANES_PER_WAVE_DEF;
            if (waves > MAX_WAVES) waves = MAX_WAVES;
            // one result per wave, last one may be partial
            for (w = 0; w < waves; w++) begin
                base = w * LANES_PER_WAVE_DEF;
                rest = (threads > base) ? threads - base : 0;
                r.wave_index   = 4'(w);
                r.engine_id    = 8'(w % engines);
                r.active_lanes = 7'((rest < LANES_PER_WAVE_DEF) ? rest : LANES_PER_WAVE_DEF);
                r.last         = (w + 1 == waves);
                add_wave(r);
            end
        endfunction

        function string rec_text(t_wave_rec r);
            return $sformatf({"st=%0d xyz=%0d/%0d/%0d cl=%0d uic=%0d gu=%0d",
                              " wave=%0d eng=%0d lanes=%0d last=%0d"},
                             r.status, r.coord_x, r.coord_y, r.coord_z, r.cluster_id,
                             r.unit_in_cluster, r.global_unit, r.wave_index,
                             r.engine_id, r.active_lanes, r.last);
        endfunction

        // compare one result with the oldest expected wave
        function void check_wave(t_wave_rec got);
            t_wave_rec want;
            if (pending_waves.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result at %0t: %s", $realtime, rec_text(got));
                return;
            end
            want = pending_waves.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", rec_text(want));
                    $display("  actual   %s", rec_text(got));
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [31:0]           i_group_id;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic [15:0]           o_coord_x;
    logic [15:0]           o_coord_y;
    logic [15:0]           o_coord_z;
    logic [11:0]           o_cluster_id;
    logic [7:0]            o_unit_in_cluster;
    logic [11:0]           o_global_unit;
    logic [3:0]            o_wave_index;
    logic [7:0]            o_engine_id;
    logic [6:0]            o_active_lanes;
    logic                  o_last;

    wave_placement_board board = new();
    int                  idle_pct;
    int                  cycle_count = 0;

    workgroup_wave_placement dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_group_id        (i_group_id),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_coord_x         (o_coord_x),
        .o_coord_y         (o_coord_y),
        .o_coord_z         (o_coord_z),
        .o_cluster_id      (o_cluster_id),
        .o_unit_in_cluster (o_unit_in_cluster),
        .o_global_unit     (o_global_unit),
        .o_wave_index      (o_wave_index),
        .o_engine_id       (o_engine_id),
        .o_active_lanes    (o_active_lanes),
        .o_last            (o_last)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_wave({o_status, o_coord_x, o_coord_y, o_coord_z, o_cluster_id,
                              o_unit_in_cluster, o_global_unit, o_wave_index,
                              o_engine_id, o_active_lanes, o_last});
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    // full register setting, plus a write to the unused index
    task automatic apply_setting(input logic [15:0] gx, input logic [15:0] gy,
                                 input logic [15:0] gz, input logic [15:0] thr,
                                 input logic [15:0] upc, input logic [15:0] tot,
                                 input logic [15:0] eng);
        write_reg(REG_GRID_X, gx);
        write_reg(REG_GRID_Y, gy);
        write_reg(REG_GRID_Z, gz);
        write_reg(REG_THREADS, thr);
        write_reg(REG_UNITS_CL, upc);
        write_reg(REG_UNITS, tot);
        write_reg(REG_ENGINES, eng);
        write_reg(REG_UNUSED, 16'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one request, with random gaps before it
    task automatic send_group(input logic [31:0] id);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
            end else begin
                start      <= 1'b1;
                i_group_id <= id;
                break;
            end
        end
        do @(posedge i_clk); while (busy);
        board.note_group(id);
    endtask

    // block idle: nothing expected and busy low
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending_waves.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0) return 16'd0;
        if (r <= 3) return 16'hFFFF;
        if (r <= 25) return 16'($urandom_range(1, 16));
        return 16'($urandom_range(1, 65535));
    endfunction

    // 8-bit counts with junk above bit 7
    function automatic logic [15:0] pick_count8();
        int r;
        logic [15:0] v;
        r = $urandom_range(0, 29);
        if (r == 0) v = 16'd0;
        else if (r == 1) v = 16'd255;
        else if (r <= 15) v = 16'($urandom_range(1, 8));
        else v = 16'($urandom_range(1, 255));
        return v | (16'($urandom) << 8);
    endfunction

    task automatic random_setting();
        int r;
        logic [15:0] thr;
        logic [15:0] tot;
        r = $urandom_range(0, 29);
        if (r == 0) thr = 16'd0;
        else if (r == 1) thr = 16'($urandom_range(1025, 2047));
        else if (r == 2) thr = 16'd1024;
        else if (r == 3) thr = 16'd1;
        else thr = 16'($urandom_range(1, 1024));
        r = $urandom_range(0, 29);
        if (r == 0) tot = 16'd0;
        else if (r == 1) tot = 16'd4095;
        else tot = 16'($urandom_range(1, 4095));
        apply_setting(pick_dim(), pick_dim(), pick_dim(),
                      thr | (16'($urandom) << 11), pick_count8(),
                      tot | (16'($urandom) << 12), pick_count8());
    endtask

    // mostly ids inside the grid, some on the boundary or anywhere
    function automatic logic [31:0] pick_group_id();
        longint unsigned total;
        int r;
        total = board.grid_x;
        total = total * board.grid_y;
        total = total * board.grid_z;
        r = $urandom_range(0, 9);
        if (total == 0 || r == 0) return $urandom;
        if (total > 64'hFFFF_FFFF) return $urandom;
        if (r == 1) return total[31:0];
        if (r == 2) return 32'(total - 1);
        return 32'({32'b0, $urandom} % total);
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_group_id  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        idle_pct    = 18;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: single group grid, one wave
        send_group(32'd0);
        send_group(32'd1);
        send_group(32'hFFFF_FFFF);
        wait_idle();

        // largest grid and device
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1024, 16'd255, 16'd4095, 16'd255);
        send_group(32'hFFFF_FFFF);
        send_group(32'd0);
        send_group(32'h8000_0000);
        send_group(32'h7FFF_FFFF);
        send_group(32'h0000_0FFE);
        wait_idle();

        // zero grid dimension beats zero unit count
        apply_setting(16'd0, 16'd1, 16'd1, 16'd64, 16'd0, 16'd1, 16'd1);
        send_group(32'd0);
        wait_idle();

        // zero group size
        apply_setting(16'd5, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
        send_group(32'd3);
        wait_idle();

        // group size above the maximum, also after masking
        apply_setting(16'd5, 16'd1, 16'd1, 16'd1025, 16'd1, 16'd1, 16'd1);
        send_group(32'd3);
        wait_idle();
        apply_setting(16'd5, 16'd1, 16'd1, 16'hFFFF, 16'd1, 16'd1, 16'd1);
        send_group(32'd3);
        wait_idle();

        // each zero unit count alone
        apply_setting(16'd5, 16'd1, 16'd1, 16'd1000, 16'd0, 16'd1, 16'd1);
        send_group(32'd2);
        wait_idle();
        apply_setting(16'd5, 16'd1, 16'd1, 16'd1000, 16'd1, 16'd0, 16'd1);
        send_group(32'd2);
        wait_idle();
        apply_setting(16'd5, 16'd1, 16'd1, 16'd1000, 16'd1, 16'd1, 16'd0);
        send_group(32'd2);
        wait_idle();

        // zero unit count beats id out of range
        apply_setting(16'd3, 16'd1, 16'd1, 16'd64, 16'd0, 16'd1, 16'd1);
        send_group(32'd100);
        wait_idle();

        // small grid: last id, first id beyond, one in the middle
        apply_setting(16'd3, 16'd4, 16'd5, 16'd1, 16'd7, 16'd13, 16'd3);
        send_group(32'd59);
        send_group(32'd60);
        send_group(32'd37);
        wait_idle();

        // partial second wave, junk in the upper data bits
        apply_setting(16'd3, 16'd4, 16'd5, 16'd65, 16'hFF07, 16'hF00D, 16'd3);
        send_group(32'd14);
        wait_idle();

        // sixteen waves, partial last one
        apply_setting(16'd7, 16'd1, 16'd1, 16'd1000, 16'd2, 16'd9, 16'd3);
        send_group(32'd6);
        wait_idle();

        // random settings and requests
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < RANDOM_PHASES / 3) idle_pct = 18;
            else if (p < 2 * RANDOM_PHASES / 3) idle_pct = 47;
            else idle_pct = 0;
            random_setting();
            repeat (GROUPS_PER_PHASE) send_group(pick_group_id());
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_waves.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
